FILE: rtl/sitda_pkg.sv
package sitda_pkg;

    // word size of the input value
    localparam int WORD_BITS = 32;

    // decimal digits needed for the largest magnitude, 2**(WORD_BITS-1)
    localparam int NUM_DIGITS = ((WORD_BITS - 1) * 30103) / 100000 + 1;

    // widths
    localparam int DIGIT_BITS = 4;
    localparam int CHAR_BITS  = 6;
    localparam int BIT_CNT_W  = $clog2(WORD_BITS);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    // ascii codes, trimmed to the character width
    localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = CHAR_BITS'(48);
    localparam logic [CHAR_BITS-1:0] ASCII_MINUS = CHAR_BITS'(45);

    // double-dabble correction
    localparam logic [DIGIT_BITS-1:0] DABBLE_LIMIT = DIGIT_BITS'(5);
    localparam logic [DIGIT_BITS-1:0] DABBLE_ADJ   = DIGIT_BITS'(3);

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CONVERT,
        S_SIGN,
        S_DIGITS
    } t_state;

    // control shared by every cell of the digit chain
    typedef struct packed {
        logic clear;
        logic dabble;
        logic digit_shift;
    } t_cell_ctrl;

endpackage

FILE: rtl/sitda_cell.sv
module sitda_cell (
    input  logic                                  i_clk,
    input  sitda_pkg::t_cell_ctrl                 i_ctrl,
    input  logic                                  i_bit_in,
    input  logic [sitda_pkg::DIGIT_BITS-1:0]      i_digit_in,
    output logic                                  o_bit_out,
    output logic [sitda_pkg::DIGIT_BITS-1:0]      o_digit
);

    logic [sitda_pkg::DIGIT_BITS-1:0] r_digit;
    logic [sitda_pkg::DIGIT_BITS-1:0] n_digit;
    logic [sitda_pkg::DIGIT_BITS-1:0] w_adj;

    // add three when the digit would overflow on doubling
    assign w_adj = (r_digit >= sitda_pkg::DABBLE_LIMIT) ?
                   (r_digit + sitda_pkg::DABBLE_ADJ) : r_digit;

    assign o_bit_out = w_adj[sitda_pkg::DIGIT_BITS-1];
    assign o_digit   = r_digit;

    // next digit: clear, shift one bit in, or take the lower neighbor's digit
    always_comb begin
        n_digit = r_digit;
        priority if (i_ctrl.clear) begin
            n_digit = '0;
        end else if (i_ctrl.dabble) begin
            n_digit = {w_adj[sitda_pkg::DIGIT_BITS-2:0], i_bit_in};
        end else if (i_ctrl.digit_shift) begin
            n_digit = i_digit_in;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

FILE: rtl/signed_int_to_decimal_ascii_core.sv
// Signed integer to decimal ASCII text.
// Input: drive i_value and raise start; the word is taken at a rising edge
// where start is high and busy is low. busy stays high until the last character
// of that number is issued; it is already low while that character is on the output.
// Output: one character per cycle on o_text_char, marked by o_strobe, most
// significant first, pausing only for skipped leading zeros: '-' for a
// negative value, then the digits without leading zeros ('0' alone for zero).
// o_final_char flags the last one. The receiver has no way to stall; every
// strobed character is taken.
// Operation: the magnitude is shifted bit-serially into a chain of BCD digit
// cells, one bit per cycle. A negative value then passes through the sign
// state. The digits are read from the top cell while the chain shifts up one
// digit a cycle; leading zeros pass without a strobe. busy covers all of
// these states, and a new word can be taken at the first edge where busy is
// low; no new number is taken before the previous one has left the digit
// state. The first character follows the conversion, or for a positive value
// the last skipped leading zero; the last comes out of the final digit state.
// Reset: synchronous, active low; returns to idle and drops o_strobe.
module signed_int_to_decimal_ascii_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [sitda_pkg::WORD_BITS-1:0] i_value,
    output logic                                  o_strobe,
    output logic [sitda_pkg::CHAR_BITS-1:0]       o_text_char,
    output logic                                  o_final_char
);

    localparam int W  = sitda_pkg::WORD_BITS;
    localparam int ND = sitda_pkg::NUM_DIGITS;

    sitda_pkg::t_state r_state;
    sitda_pkg::t_state n_state;

    logic [W-1:0]                        r_mag;
    logic                                r_neg;
    logic [sitda_pkg::BIT_CNT_W-1:0]     r_bit_cnt;
    logic [sitda_pkg::DIG_CNT_W-1:0]     r_dig_cnt;
    logic                                r_started;
    logic                                r_strobe;
    logic [sitda_pkg::CHAR_BITS-1:0]     r_text_char;
    logic                                r_final_char;

    logic [W-1:0]                        w_raw;
    logic [W-1:0]                        w_mag;
    logic                                w_accept;
    logic                                w_last_bit;
    logic                                w_last_digit;
    logic                                w_skip;
    logic                                w_emit;
    logic [sitda_pkg::CHAR_BITS-1:0]     w_emit_char;
    logic                                w_emit_final;
    logic                                w_digit_emit;
    sitda_pkg::t_cell_ctrl               w_ctrl;
    logic [sitda_pkg::DIGIT_BITS-1:0]    w_top;

    logic [sitda_pkg::DIGIT_BITS-1:0]    w_digit [ND];
    logic                                w_bit   [ND];

    function automatic logic [W-1:0] w_raw_of(input logic signed [W-1:0] v);
        return W'(unsigned'(v));
    endfunction

    // magnitude, exact for the most negative value
    assign w_raw = w_raw_of(i_value);
    assign w_mag = w_raw[W-1] ? (~w_raw + W'(1)) : w_raw;

    assign busy         = (r_state != sitda_pkg::S_IDLE);
    assign w_accept     = start && !busy;
    assign w_last_bit   = (r_bit_cnt == sitda_pkg::BIT_CNT_W'(W - 1));
    assign w_last_digit = (r_dig_cnt == sitda_pkg::DIG_CNT_W'(1));
    assign w_top        = w_digit[ND-1];

    // digit chain, lowest cell takes the magnitude msb
    // the top cell's carry stays low since the largest magnitude fits
    for (genvar i = 0; i < ND; i++) begin : g_cell
        logic                             w_bin;
        logic [sitda_pkg::DIGIT_BITS-1:0] w_din;
        if (i == 0) begin : g_low
            assign w_bin = r_mag[W-1];
            assign w_din = '0;
        end else begin : g_mid
            assign w_bin = w_bit[i-1];
            assign w_din = w_digit[i-1];
        end
        sitda_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_bit_in   (w_bin),
            .i_digit_in (w_din),
            .o_bit_out  (w_bit[i]),
            .o_digit    (w_digit[i])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sitda_pkg::S_IDLE: begin
                if (start) n_state = sitda_pkg::S_CONVERT;
            end
            sitda_pkg::S_CONVERT: begin
                if (w_last_bit) n_state = r_neg ? sitda_pkg::S_SIGN : sitda_pkg::S_DIGITS;
            end
            sitda_pkg::S_SIGN: begin
                n_state = sitda_pkg::S_DIGITS;
            end
            sitda_pkg::S_DIGITS: begin
                if (w_last_digit) n_state = sitda_pkg::S_IDLE;
            end
            default: begin
                n_state = sitda_pkg::S_IDLE;
            end
        endcase
    end

    // state outputs: chain control and the character to send
    always_comb begin
        w_ctrl       = '0;
        w_skip       = 1'b0;
        w_emit       = 1'b0;
        w_digit_emit = 1'b0;
        w_emit_char  = sitda_pkg::ASCII_ZERO + sitda_pkg::CHAR_BITS'(w_top);
        w_emit_final = 1'b0;
        unique case (r_state)
            sitda_pkg::S_IDLE: begin
                w_ctrl.clear = w_accept;
            end
            sitda_pkg::S_CONVERT: begin
                w_ctrl.dabble = 1'b1;
            end
            sitda_pkg::S_SIGN: begin
                w_emit      = 1'b1;
                w_emit_char = sitda_pkg::ASCII_MINUS;
            end
            sitda_pkg::S_DIGITS: begin
                w_ctrl.digit_shift = 1'b1;
                w_skip       = (w_top == '0) && !r_started && !w_last_digit;
                w_emit       = !w_skip;
                w_digit_emit = !w_skip;
                w_emit_final = w_last_digit;
            end
            default: begin
                w_ctrl = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sitda_pkg::S_IDLE;
            r_strobe  <= 1'b0;
            r_started <= 1'b0;
            r_bit_cnt <= '0;
            r_dig_cnt <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= w_emit;
            if (w_accept) begin
                r_started <= 1'b0;
                r_bit_cnt <= '0;
                r_dig_cnt <= sitda_pkg::DIG_CNT_W'(ND);
            end else begin
                if (r_state == sitda_pkg::S_CONVERT) begin
                    r_bit_cnt <= r_bit_cnt + sitda_pkg::BIT_CNT_W'(1);
                end
                if (r_state == sitda_pkg::S_DIGITS) begin
                    r_dig_cnt <= r_dig_cnt - sitda_pkg::DIG_CNT_W'(1);
                end
                if (w_digit_emit) begin
                    r_started <= 1'b1;
                end
            end
        end
    end

    // magnitude shifter and sign
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mag <= w_mag;
            r_neg <= w_raw[W-1];
        end else if (r_state == sitda_pkg::S_CONVERT) begin
            r_mag <= {r_mag[W-2:0], 1'b0};
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_text_char  <= w_emit_char;
            r_final_char <= w_emit_final;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_text_char  = r_text_char;
    assign o_final_char = r_final_char;

endmodule

FILE: rtl/sitda_checker.sv
module sitda_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    input  logic                                   busy,
    input  logic signed [sitda_pkg::WORD_BITS-1:0] i_value,
    input  logic                                   o_strobe,
    input  logic [sitda_pkg::CHAR_BITS-1:0]        o_text_char,
    input  logic                                   o_final_char
);

    // only the sign or a decimal digit is ever sent
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_text_char == sitda_pkg::ASCII_MINUS) ||
                     ((o_text_char >= sitda_pkg::ASCII_ZERO) &&
                      (o_text_char <= sitda_pkg::ASCII_ZERO + sitda_pkg::CHAR_BITS'(9))))
        else $error("illegal character on output");

    // the sign never ends a number
    a_sign_not_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_text_char == sitda_pkg::ASCII_MINUS)) |-> !o_final_char)
        else $error("minus sign flagged as final");

    // a word that is not the last leaves while the block is still busy
    a_mid_word_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_final_char) |-> busy)
        else $error("non-final word while idle");

    // an accepted number keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // no word leaves right after a new number is taken
    a_no_early_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> !o_strobe)
        else $error("word right after accept");

endmodule

bind signed_int_to_decimal_ascii_core sitda_checker u_sitda_checker (.*);
